>>> rtl/pvp_pkg.sv
// Package: payload types, codes and sizing constants of the vertex projector.
`default_nettype none
package pvp_pkg;

    localparam int NUM_CAMERAS   = 8;
    localparam int FRAC_BITS     = 16;
    localparam int WORDS_PER_CAM = 12;
    localparam int CAM_AW        = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
    localparam int DIV_STEPS     = 32;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PROJECT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_SAT  = 2'd1,
        STATUS_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        logic               kind;
        logic [2:0]         camera_index;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] image_u;
        logic signed [31:0] image_v;
        logic [1:0]         status;
    } t_out;

    // One divider lane: partial remainder, dividend bits still to shift in, quotient.
    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] bits;
        logic [31:0] quo;
    } t_lane;

    // Side information that travels with an item through the divider.
    typedef struct packed {
        logic        valid;
        logic [63:0] den;
        logic        neg_u;
        logic        neg_v;
        logic        ovf_u;
        logic        ovf_v;
        logic        zero;
    } t_ctl;

endpackage
`default_nettype wire

>>> rtl/pvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pvp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/pvp_div_step.sv
// One registered restoring-division step of a divider lane.
`default_nettype none
module pvp_div_step (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [63:0]   i_den,
    input  wire pvp_pkg::t_lane i_lane,
    output pvp_pkg::t_lane     o_lane
);
    import pvp_pkg::*;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        take;
    t_lane       n_lane;

    always_comb begin
        trial = {i_lane.rem, i_lane.bits[31]};
        diff  = trial - {1'b0, i_den};
        take  = (trial >= {1'b0, i_den});
        n_lane.rem  = take ? diff[63:0] : trial[63:0];
        n_lane.bits = {i_lane.bits[30:0], 1'b0};
        n_lane.quo  = {i_lane.quo[30:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lane <= n_lane;
        end
    end

endmodule
`default_nettype wire

>>> rtl/pinhole_vertex_projector_core.sv
// Top level of the pinhole vertex projector: matrix store, 3x4 product, divider.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_ready  | i_data (t_in)
//  output  | out       | o_valid / i_ready  | o_data (t_out)
//
// One item enters per cycle while the output is not stalled. A project item's result passes
// 39 registers, the first loaded at the edge that accepts it: RAM read, multiply, two add
// stages, magnitude, divider setup, 32 divide steps, output. The depth is set by the
// one-quotient-bit-per-stage divider.
// Load items write an in-range matrix word on acceptance and produce no result.
// Reset clears the valid bits only; matrix words are undefined until loaded.
// A stall at the output freezes every stage at once; nothing is lost or repeated.
`default_nettype none
module pinhole_vertex_projector_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire pvp_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output pvp_pkg::t_out      o_data
);
    import pvp_pkg::*;

    logic adv;
    logic accept;
    logic cam_ok_in;
    logic [CAM_AW-1:0] cam_addr;
    logic [31:0] rd_word [0:WORDS_PER_CAM-1];

    // advance the whole pipe whenever the output register can move
    assign adv      = !o_valid || i_ready;
    assign o_ready  = adv;
    assign accept   = i_valid && adv;
    assign cam_ok_in = (32'(i_data.camera_index) < NUM_CAMERAS);
    assign cam_addr = CAM_AW'(i_data.camera_index);

    // one RAM per matrix entry, addressed by camera, so all words of a camera's matrix read together
    for (genvar e = 0; e < WORDS_PER_CAM; e++) begin : g_ram
        logic we;
        assign we = accept && (i_data.kind == KIND_LOAD) && cam_ok_in
                    && (i_data.entry_index == 4'(e));
        pvp_ram #(.WIDTH(32), .DEPTH(NUM_CAMERAS)) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (cam_addr),
            .i_wdata (i_data.entry_value),
            .i_re    (accept),
            .i_raddr (cam_addr),
            .o_rdata (rd_word[e])
        );
    end

    // stage 1: vertex beside RAM read data
    logic               r_s1_valid;
    logic               r_s1_cam_ok;
    logic signed [31:0] r_s1_x, r_s1_y, r_s1_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept && (i_data.kind == KIND_PROJECT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cam_ok <= cam_ok_in;
            r_s1_x      <= i_data.vertex_x;
            r_s1_y      <= i_data.vertex_y;
            r_s1_z      <= i_data.vertex_z;
        end
    end

    // stage 2: nine products and the three scaled constant terms
    logic               r_s2_valid;
    logic signed [63:0] r_prod  [0:2][0:2];
    logic signed [65:0] r_const [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        logic signed [31:0] m0, m1, m2, m3;
        // camera out of range reads an all-zero matrix
        assign m0 = r_s1_cam_ok ? rd_word[4*r]   : 32'sd0;
        assign m1 = r_s1_cam_ok ? rd_word[4*r+1] : 32'sd0;
        assign m2 = r_s1_cam_ok ? rd_word[4*r+2] : 32'sd0;
        assign m3 = r_s1_cam_ok ? rd_word[4*r+3] : 32'sd0;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_prod[r][0] <= m0 * r_s1_x;
                r_prod[r][1] <= m1 * r_s1_y;
                r_prod[r][2] <= m2 * r_s1_z;
                r_const[r]   <= {{34{m3[31]}}, m3} <<< FRAC_BITS;
            end
        end
    end

    // stage 3: pairwise sums; stage 4: row sums
    logic               r_s3_valid, r_s4_valid;
    logic signed [65:0] r_sa [0:2];
    logic signed [65:0] r_sb [0:2];
    logic signed [65:0] r_n  [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_sa[r] <= {{2{r_prod[r][0][63]}}, r_prod[r][0]}
                         + {{2{r_prod[r][1][63]}}, r_prod[r][1]};
                r_sb[r] <= {{2{r_prod[r][2][63]}}, r_prod[r][2]} + r_const[r];
                r_n[r]  <= r_sa[r] + r_sb[r];
            end
        end
    end

    // stage 5: sign and magnitude; every magnitude fits in 64 bits
    logic        r_s5_valid;
    logic [63:0] r_mag [0:2];
    logic        r_neg [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (adv) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_neg[r] <= r_n[r][65];
                r_mag[r] <= r_n[r][65] ? 64'(-r_n[r]) : r_n[r][63:0];
            end
        end
    end

    // stage 6: divider setup. The dividend is num << FRAC; its top 64 bits start the
    // remainder and the low 32 bits are shifted in one per step. A quotient of 2^32 or
    // more shows as num >> (32 - FRAC) >= den.
    t_ctl  r_ctl    [0:DIV_STEPS];
    t_lane r_lane_u [0:DIV_STEPS];
    t_lane r_lane_v [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].valid <= 1'b0;
        end else if (adv) begin
            r_ctl[0].valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctl[0].den   <= r_mag[2];
            r_ctl[0].neg_u <= r_neg[0] ^ r_neg[2];
            r_ctl[0].neg_v <= r_neg[1] ^ r_neg[2];
            r_ctl[0].ovf_u <= (64'(r_mag[0] >> (32 - FRAC_BITS)) >= r_mag[2]);
            r_ctl[0].ovf_v <= (64'(r_mag[1] >> (32 - FRAC_BITS)) >= r_mag[2]);
            r_ctl[0].zero  <= (r_mag[2] == 64'd0);
            r_lane_u[0].rem  <= 64'(r_mag[0] >> (32 - FRAC_BITS));
            r_lane_u[0].bits <= 32'(r_mag[0][31-FRAC_BITS:0]) << FRAC_BITS;
            r_lane_u[0].quo  <= 32'd0;
            r_lane_v[0].rem  <= 64'(r_mag[1] >> (32 - FRAC_BITS));
            r_lane_v[0].bits <= 32'(r_mag[1][31-FRAC_BITS:0]) << FRAC_BITS;
            r_lane_v[0].quo  <= 32'd0;
        end
    end

    // divide steps: one quotient bit per stage for each coordinate
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        pvp_div_step u_step_u (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_den  (r_ctl[k].den),
            .i_lane (r_lane_u[k]),
            .o_lane (r_lane_u[k+1])
        );
        pvp_div_step u_step_v (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_den  (r_ctl[k].den),
            .i_lane (r_lane_v[k]),
            .o_lane (r_lane_v[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1].valid <= 1'b0;
            end else if (adv) begin
                r_ctl[k+1].valid <= r_ctl[k].valid;
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ctl[k+1].den   <= r_ctl[k].den;
                r_ctl[k+1].neg_u <= r_ctl[k].neg_u;
                r_ctl[k+1].neg_v <= r_ctl[k].neg_v;
                r_ctl[k+1].ovf_u <= r_ctl[k].ovf_u;
                r_ctl[k+1].ovf_v <= r_ctl[k].ovf_v;
                r_ctl[k+1].zero  <= r_ctl[k].zero;
            end
        end
    end

    // saturate and apply the sign; bit 32 of the result flags saturation
    function automatic logic [32:0] sat_sign(input logic [31:0] q, input logic neg,
                                             input logic ovf);
        logic [32:0] res;
        if (!neg) begin
            if (ovf || (q > 32'h7FFF_FFFF)) begin
                res = {1'b1, 32'h7FFF_FFFF};
            end else begin
                res = {1'b0, q};
            end
        end else begin
            if (ovf || (q > 32'h8000_0000)) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, 32'(-q)};
            end
        end
        return res;
    endfunction

    logic [32:0] res_u, res_v;
    t_out        n_out;
    t_ctl        ctl_end;

    assign ctl_end = r_ctl[DIV_STEPS];

    always_comb begin
        res_u = sat_sign(r_lane_u[DIV_STEPS].quo, ctl_end.neg_u, ctl_end.ovf_u);
        res_v = sat_sign(r_lane_v[DIV_STEPS].quo, ctl_end.neg_v, ctl_end.ovf_v);
        if (ctl_end.zero) begin
            n_out.image_u = 32'sd0;
            n_out.image_v = 32'sd0;
            n_out.status  = STATUS_ZERO;
        end else begin
            n_out.image_u = res_u[31:0];
            n_out.image_v = res_v[31:0];
            n_out.status  = (res_u[32] || res_v[32]) ? STATUS_SAT : STATUS_OK;
        end
    end

    // output register: hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= ctl_end.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_data <= n_out;
        end
    end

endmodule
`default_nettype wire

>>> rtl/pvp_checker.sv
// Port-level checker of the vertex projector and its bind to the top level.
`default_nettype none
module pvp_sva (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_ready,
    input wire logic          o_valid,
    input wire logic          i_ready,
    input wire pvp_pkg::t_out o_data
);
    import pvp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("output item changed while stalled");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status == STATUS_ZERO))
            |-> ((o_data.image_u == 32'sd0) && (o_data.image_v == 32'sd0)))
        else $error("zero denominator item carries nonzero coordinates");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.status == STATUS_OK) || (o_data.status == STATUS_SAT)
                     || (o_data.status == STATUS_ZERO)))
        else $error("undefined status code");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while output stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind pinhole_vertex_projector_core pvp_sva u_pvp_sva (.*);
`default_nettype wire
